// ===== rtl/core/rgbc_pkg.sv =====
// Package for the streaming 3x3 RGB convolution block.
// Holds payload structs, configuration and kernel codes, kernel weights and
// the per-channel filter function. No dependencies.
package rgbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
  localparam int IN_ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W    = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W   = 24;
  localparam int TAPS    = 9;
  localparam int SUM_W   = 14;
  localparam int PIX_MAX = 255;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = WIDTH_CFG_W'(1024);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = HEIGHT_CFG_W'(768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_KERNEL_SELECT = 2'd2,
    CFG_FIX_BORDERS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KERNEL_BLUR    = 2'd0,
    KERNEL_SHARPEN = 2'd1,
    KERNEL_EMBOSS  = 2'd2,
    KERNEL_EDGE    = 2'd3
  } kernel_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  localparam logic signed [4:0] KERNEL_WEIGHTS [4][TAPS] = '{
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2, 5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1, 5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{-5'sd2, -5'sd1,  5'sd0, -5'sd1, 5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd2},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1}
  };

  function automatic logic [7:0] conv_channel(kernel_t kernel,
                                              logic [TAPS-1:0][7:0] taps,
                                              logic [TAPS-1:0] keep);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wt;
    logic signed [SUM_W-1:0] px;
    logic [7:0]              res;
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      wt = SUM_W'(KERNEL_WEIGHTS[kernel][i]);
      px = SUM_W'(taps[i]);
      if (keep[i]) begin
        sum = sum + wt * px;
      end
    end
    if (kernel == KERNEL_BLUR) begin
      sum = sum >>> 4;
    end
    if (sum < 0) begin
      res = '0;
    end else if (sum > PIX_MAX) begin
      res = 8'(PIX_MAX);
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/rgb_conv3x3_stream.sv =====
// Streaming 3x3 RGB convolution with two line stores and a 3x3 window.
// Depends on rgbc_pkg.
// Throughput: one item per cycle unless out_stall holds the pipeline. Results
// are registered after the item one row plus one pixel past their pixel.
// Reset (synchronous, rst_n low) clears counters, window, pipeline valids and
// configuration to defaults; line stores are not cleared and need no pass.
module rgb_conv3x3_stream (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  rgbc_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rgbc_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } edge_flags_t;

  logic [rgbc_pkg::WIDTH_CFG_W-1:0]  img_width_r;
  logic [rgbc_pkg::HEIGHT_CFG_W-1:0] img_height_r;
  rgbc_pkg::kernel_t                 kernel_sel_r;
  logic                              fix_borders_r;

  logic [rgbc_pkg::WEFF_W-1:0] width_eff;
  logic [rgbc_pkg::HEFF_W-1:0] height_eff;

  logic [rgbc_pkg::COL_W-1:0]     in_col_r, in_col_nxt;
  logic [rgbc_pkg::IN_ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [rgbc_pkg::COL_W-1:0]     out_col_r, out_col_nxt;
  logic [rgbc_pkg::OUT_ROW_W-1:0] out_row_r, out_row_nxt;

  logic [rgbc_pkg::PIX_W-1:0] upper_mem [rgbc_pkg::MAX_WIDTH];
  logic [rgbc_pkg::PIX_W-1:0] middle_mem [rgbc_pkg::MAX_WIDTH];
  logic [rgbc_pkg::PIX_W-1:0] up_rd_r;
  logic [rgbc_pkg::PIX_W-1:0] mid_rd_r;

  logic                        s1_v_r;
  logic [rgbc_pkg::PIX_W-1:0]  s1_pix_r;
  logic [rgbc_pkg::COL_W-1:0]  s1_col_r;
  logic                        s1_emit_r;
  edge_flags_t                 s1_edge_r;

  logic                        s2_v_r;
  logic                        s2_emit_r;
  edge_flags_t                 s2_edge_r;
  logic [rgbc_pkg::PIX_W-1:0]  window_r [rgbc_pkg::TAPS];
  logic                        win_clr_r;

  logic                        out_valid_r;
  rgbc_pkg::out_item_t         out_data_r;
  rgbc_pkg::out_item_t         result;

  logic        in_fire, input_done, drain, live, emit, cfg_restart;
  logic        out_free, s2_adv, s2_free, s1_adv, s1_free;
  logic [rgbc_pkg::PIX_W-1:0] pix_in;
  edge_flags_t edge_in;
  logic [rgbc_pkg::TAPS-1:0]  keep;
  logic [rgbc_pkg::TAPS-1:0][7:0] taps_red, taps_green, taps_blue;

  // effective frame size
  always_comb begin
    if (img_width_r == '0) begin
      width_eff = rgbc_pkg::WEFF_W'(1);
    end else if (32'(img_width_r) > 32'(rgbc_pkg::MAX_WIDTH)) begin
      width_eff = rgbc_pkg::WEFF_W'(rgbc_pkg::MAX_WIDTH);
    end else begin
      width_eff = rgbc_pkg::WEFF_W'(img_width_r);
    end
    if (img_height_r == '0) begin
      height_eff = rgbc_pkg::HEFF_W'(1);
    end else if (32'(img_height_r) > 32'(rgbc_pkg::MAX_HEIGHT)) begin
      height_eff = rgbc_pkg::HEFF_W'(rgbc_pkg::MAX_HEIGHT);
    end else begin
      height_eff = rgbc_pkg::HEFF_W'(img_height_r);
    end
  end

  // pipeline flow
  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_v_r && (!s2_emit_r || out_free);
  assign s2_free  = !s2_v_r || s2_adv;
  assign s1_adv   = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_adv;
  assign in_stall = !s1_free;

  assign cfg_restart = cfg_we &&
                       (cfg_index == rgbc_pkg::CFG_IMAGE_WIDTH ||
                        cfg_index == rgbc_pkg::CFG_IMAGE_HEIGHT);

  assign in_fire    = in_valid && !in_stall;
  assign input_done = 32'(in_row_r) >= 32'(height_eff);
  assign drain      = (in_data.operation == rgbc_pkg::OP_DRAIN) || input_done;
  // drop a drain item that arrives before the frame's last pixel
  assign live       = in_fire && (!drain || input_done);
  assign pix_in     = drain ? '0 : {in_data.pixel_red, in_data.pixel_green,
                                    in_data.pixel_blue};
  assign emit       = (32'(in_row_r) >= 32'd2) ||
                      (in_row_r == rgbc_pkg::IN_ROW_W'(1) && in_col_r != '0);

  always_comb begin
    edge_in.top    = out_row_r == '0;
    edge_in.bottom = 32'(out_row_r) + 32'd1 >= 32'(height_eff);
    edge_in.left   = out_col_r == '0;
    edge_in.right  = 32'(out_col_r) + 32'd1 >= 32'(width_eff);
    edge_in.last   = edge_in.bottom && edge_in.right;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (live) begin
      if (32'(in_col_r) + 32'd1 >= 32'(width_eff)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + rgbc_pkg::IN_ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + rgbc_pkg::COL_W'(1);
      end
      if (emit) begin
        if (edge_in.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (edge_in.right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + rgbc_pkg::OUT_ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + rgbc_pkg::COL_W'(1);
        end
      end
    end
  end

  // line stores: read on transfer, write when the item leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      upper_mem[s1_col_r] <= mid_rd_r;
    end
    if (live) begin
      up_rd_r <= (s1_adv && s1_col_r == in_col_r) ? mid_rd_r : upper_mem[in_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      middle_mem[s1_col_r] <= s1_pix_r;
    end
    if (live) begin
      mid_rd_r <= (s1_adv && s1_col_r == in_col_r) ? s1_pix_r : middle_mem[in_col_r];
    end
  end

  // filter on the registered window
  always_comb begin
    for (int t = 0; t < rgbc_pkg::TAPS; t++) begin
      taps_red[t]   = window_r[t][23:16];
      taps_green[t] = window_r[t][15:8];
      taps_blue[t]  = window_r[t][7:0];
      keep[t] = !((t / 3 == 0) && s2_edge_r.top) && !((t / 3 == 2) && s2_edge_r.bottom) &&
                !((t % 3 == 0) && s2_edge_r.left) && !((t % 3 == 2) && s2_edge_r.right);
    end
    if (fix_borders_r && (s2_edge_r.top || s2_edge_r.bottom ||
                          s2_edge_r.left || s2_edge_r.right)) begin
      result.out_red   = '0;
      result.out_green = '0;
      result.out_blue  = '0;
    end else begin
      result.out_red   = rgbc_pkg::conv_channel(kernel_sel_r, taps_red, keep);
      result.out_green = rgbc_pkg::conv_channel(kernel_sel_r, taps_green, keep);
      result.out_blue  = rgbc_pkg::conv_channel(kernel_sel_r, taps_blue, keep);
    end
    result.frame_end = s2_edge_r.last;
  end

  always_ff @(posedge clk) begin
    if (live) begin
      s1_pix_r  <= pix_in;
      s1_col_r  <= in_col_r;
      s1_emit_r <= emit;
      s1_edge_r <= edge_in;
    end
    if (s1_adv) begin
      s2_emit_r <= s1_emit_r;
      s2_edge_r <= s1_edge_r;
    end
    if (s2_adv && s2_emit_r) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r   <= rgbc_pkg::WIDTH_RESET;
      img_height_r  <= rgbc_pkg::HEIGHT_RESET;
      kernel_sel_r  <= rgbc_pkg::KERNEL_BLUR;
      fix_borders_r <= 1'b0;
      in_col_r      <= '0;
      in_row_r      <= '0;
      out_col_r     <= '0;
      out_row_r     <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      win_clr_r     <= 1'b0;
      for (int t = 0; t < rgbc_pkg::TAPS; t++) begin
        window_r[t] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (rgbc_pkg::cfg_reg_t'(cfg_index))
          rgbc_pkg::CFG_IMAGE_WIDTH:   img_width_r  <= cfg_data[rgbc_pkg::WIDTH_CFG_W-1:0];
          rgbc_pkg::CFG_IMAGE_HEIGHT:  img_height_r <= cfg_data[rgbc_pkg::HEIGHT_CFG_W-1:0];
          rgbc_pkg::CFG_KERNEL_SELECT: kernel_sel_r <= rgbc_pkg::kernel_t'(cfg_data[1:0]);
          rgbc_pkg::CFG_FIX_BORDERS:   fix_borders_r <= cfg_data[0];
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;

      if (live) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv && s2_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end

      // shift the window; clear it after the frame's last result
      if (cfg_restart) begin
        win_clr_r <= 1'b0;
        for (int t = 0; t < rgbc_pkg::TAPS; t++) begin
          window_r[t] <= '0;
        end
      end else if (s1_adv) begin
        win_clr_r <= s1_emit_r && s1_edge_r.last;
        for (int k = 0; k < 3; k++) begin
          window_r[k*3]     <= win_clr_r ? '0 : window_r[k*3 + 1];
          window_r[k*3 + 1] <= win_clr_r ? '0 : window_r[k*3 + 2];
        end
        window_r[2] <= up_rd_r;
        window_r[5] <= mid_rd_r;
        window_r[8] <= s1_pix_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/rgbc_checker.sv =====
// Port-level checks for rgb_conv3x3_stream, attached by bind.
// Depends on rgbc_pkg and the top level's port names.
module rgbc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rgbc_pkg::out_item_t out_data
);

  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind rgb_conv3x3_stream rgbc_checker u_rgbc_checker (.*);

// ===== tb/rgbc_tb_pkg.sv =====
// Pixel predictor and result scoreboard for the streaming 3x3 RGB convolution.
// Depends on rgbc_pkg for the payload structs, kernel and register codes.
package rgbc_tb_pkg;

  localparam int KERNEL_TAPS [4][9] = '{
    '{ 1,  2,  1,  2, 4,  2,  1,  2,  1},
    '{ 0, -1,  0, -1, 5, -1,  0, -1,  0},
    '{-2, -1,  0, -1, 1,  1,  0,  1,  2},
    '{-1, -1, -1, -1, 8, -1, -1, -1, -1}
  };

  class filtered_pixel_board;
    int unsigned         width_reg;
    int unsigned         height_reg;
    rgbc_pkg::kernel_t   kern;
    bit                  fix_border;
    bit [23:0]           upper_store [rgbc_pkg::MAX_WIDTH];
    bit [23:0]           middle_store [rgbc_pkg::MAX_WIDTH];
    bit [23:0]           win [9];
    int                  in_col, in_row, out_col, out_row;
    rgbc_pkg::out_item_t awaited [$];
    int                  errors, checked, pixels, frames;

    function new();
      width_reg  = 1024;
      height_reg = 768;
      kern       = rgbc_pkg::KERNEL_BLUR;
      fix_border = 1'b0;
      restart();
    endfunction

    function void restart();
      foreach (win[k]) win[k] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > rgbc_pkg::MAX_WIDTH) return rgbc_pkg::MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > rgbc_pkg::MAX_HEIGHT) return rgbc_pkg::MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function void write_reg(rgbc_pkg::cfg_reg_t idx, logic [rgbc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rgbc_pkg::CFG_IMAGE_WIDTH: begin
          width_reg = 32'(val[rgbc_pkg::WIDTH_CFG_W-1:0]);
          restart();
        end
        rgbc_pkg::CFG_IMAGE_HEIGHT: begin
          height_reg = 32'(val[rgbc_pkg::HEIGHT_CFG_W-1:0]);
          restart();
        end
        rgbc_pkg::CFG_KERNEL_SELECT: kern = rgbc_pkg::kernel_t'(val[1:0]);
        rgbc_pkg::CFG_FIX_BORDERS:   fix_border = val[0];
        default: ;
      endcase
    endfunction

    function bit tail_pending();
      return in_row >= eff_height();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int channel(int shift, int w, int h);
      int sum, rr, cc, px;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rr = out_row + i - 1;
          cc = out_col + j - 1;
          if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
          px = int'((win[i*3+j] >> shift) & 24'hFF);
          sum += KERNEL_TAPS[int'(kern)][i*3+j] * px;
        end
      end
      if (kern == rgbc_pkg::KERNEL_BLUR) sum = sum / 16;
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      return sum;
    endfunction

    function void accept_item(rgbc_pkg::in_item_t it);
      int                  w, h, col;
      bit                  done, drain, emit, last, border;
      bit [23:0]           pix, up, mid;
      rgbc_pkg::out_item_t res;
      w     = eff_width();
      h     = eff_height();
      done  = in_row >= h;
      drain = (it.operation == rgbc_pkg::OP_DRAIN) || done;
      if (drain && !done) return;
      pix = drain ? 24'h0 : {it.pixel_red, it.pixel_green, it.pixel_blue};
      if (!drain) pixels++;
      col = (in_col >= rgbc_pkg::MAX_WIDTH) ? rgbc_pkg::MAX_WIDTH - 1 : in_col;
      up  = upper_store[col];
      mid = middle_store[col];
      upper_store[col]  = mid;
      middle_store[col] = pix;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = pix;
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;
      border = out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w;
      if (fix_border && border) begin
        res.out_red   = 8'd0;
        res.out_green = 8'd0;
        res.out_blue  = 8'd0;
      end else begin
        res.out_red   = 8'(channel(16, w, h));
        res.out_green = 8'(channel(8, w, h));
        res.out_blue  = 8'(channel(0, w, h));
      end
      last = out_row + 1 >= h && out_col + 1 >= w;
      res.frame_end = last;
      awaited.push_back(res);
      if (last) begin
        frames++;
        restart();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void report(string field, int want, int seen);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    endfunction

    function void check_pixel(rgbc_pkg::out_item_t got);
      rgbc_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited, expected none, actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.out_red !== want.out_red) report("out_red", want.out_red, got.out_red);
      if (got.out_green !== want.out_green) report("out_green", want.out_green, got.out_green);
      if (got.out_blue !== want.out_blue) report("out_blue", want.out_blue, got.out_blue);
      if (got.frame_end !== want.frame_end) report("frame_end", want.frame_end, got.frame_end);
    endfunction

    function void close_out();
      rgbc_pkg::out_item_t want;
      while (awaited.size() > 0) begin
        want = awaited.pop_front();
        errors++;
        $display("%0t: result missing, expected %h, actual none", $time, want);
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_rgb_conv3x3_stream.sv =====
// Self-checking bench for rgb_conv3x3_stream: directed frames, size extremes
// and random frames under bursty input and random output stalls.
// Depends on rgbc_pkg and rgbc_tb_pkg.
module tb_rgb_conv3x3_stream;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  rgbc_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  rgbc_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  rgbc_tb_pkg::filtered_pixel_board board = new();
  int burst_left = 0;
  int stim_count = 0;
  int phases     = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  rgb_conv3x3_stream u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5 < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_pixel(out_data);
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic cfg_write(rgbc_pkg::cfg_reg_t idx, logic [rgbc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(int unsigned w, int unsigned h, rgbc_pkg::kernel_t k, bit f);
    logic [rgbc_pkg::CFG_DATA_W-1:0] vals [4];
    int                              first;
    vals[0] = rgbc_pkg::CFG_DATA_W'(w);
    vals[1] = rgbc_pkg::CFG_DATA_W'(h);
    vals[2] = rgbc_pkg::CFG_DATA_W'(k);
    vals[3] = rgbc_pkg::CFG_DATA_W'(f);
    first   = $urandom_range(0, 3);
    for (int n = 0; n < 4; n++) begin
      cfg_write(rgbc_pkg::cfg_reg_t'((first + n) % 4), vals[(first + n) % 4]);
    end
    phases++;
  endtask

  task automatic send(rgbc_pkg::op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgbc_pkg::in_item_t it;
    int                 gap;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.operation   = op;
    it.pixel_red   = r;
    it.pixel_green = g;
    it.pixel_blue  = b;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    board.accept_item(it);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_frame(int npix, bit close_frame, bit counted);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send(rgbc_pkg::OP_DRAIN, pick_level(), pick_level(), pick_level());
      end
      if ($urandom_range(0, 399) == 0) hold_until_drained();
      send(rgbc_pkg::OP_PIXEL, pick_level(), pick_level(), pick_level());
      if (counted) stim_count++;
    end
    if (close_frame) begin
      while (board.tail_pending()) begin
        if ($urandom_range(0, 3) == 0) begin
          send(rgbc_pkg::OP_PIXEL, pick_level(), pick_level(), pick_level());
        end else begin
          send(rgbc_pkg::OP_DRAIN, pick_level(), pick_level(), pick_level());
        end
        if (counted) stim_count++;
      end
    end
  endtask

  initial begin
    int          waited;
    int unsigned w, h;
    int          npix;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    setup(3, 3, rgbc_pkg::KERNEL_EDGE, 1'b0);
    for (int k = 0; k < 9; k++) begin
      if (k == 3) send(rgbc_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      if (k == 5) hold_until_drained();
      send(rgbc_pkg::OP_PIXEL, (k == 4) ? 8'hFF : 8'h00, (k % 2) ? 8'hFF : 8'h00,
           (k >= 6) ? 8'hFF : 8'h00);
    end
    send(rgbc_pkg::OP_PIXEL, 8'hA5, 8'h5A, 8'hC3);
    while (board.tail_pending()) send(rgbc_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
    settle();

    setup(2, 2, rgbc_pkg::KERNEL_BLUR, 1'b1);
    repeat (4) send(rgbc_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    while (board.tail_pending()) send(rgbc_pkg::OP_DRAIN, 8'hFF, 8'h00, 8'hFF);
    settle();

    setup(1, 1, rgbc_pkg::KERNEL_SHARPEN, 1'b0);
    send(rgbc_pkg::OP_PIXEL, 8'hFF, 8'h80, 8'h01);
    while (board.tail_pending()) send(rgbc_pkg::OP_DRAIN, 8'h00, 8'hFF, 8'h00);
    settle();

    setup(2047, 1, rgbc_pkg::KERNEL_EMBOSS, 1'b0);
    run_frame(1030, 1'b0, 1'b0);
    settle();

    setup('h801, 8191, rgbc_pkg::KERNEL_BLUR, 1'b0);
    run_frame(80, 1'b0, 1'b0);
    settle();

    while (stim_count < 800) begin
      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = 'h800 | $urandom_range(1, 8);
        2, 3:    w = $urandom_range(20, 64);
        default: w = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 19))
        0:       h = 0;
        1, 2:    h = $urandom_range(9, 16);
        default: h = $urandom_range(1, 6);
      endcase
      setup(w, h, rgbc_pkg::kernel_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      npix = board.eff_width() * board.eff_height();
      if ($urandom_range(0, 7) == 0) run_frame($urandom_range(0, npix - 1), 1'b0, 1'b1);
      else run_frame(npix, 1'b1, 1'b1);
      settle();
    end

    in_valid <= 1'b0;
    for (waited = 0; waited < 5000 && board.pending() != 0; waited++) @(posedge clk);
    repeat (10) @(posedge clk);
    board.close_out();

    $display("Run covered %0d pixels, %0d results checked and %0d whole frames",
             board.pixels, board.checked, stim_count == 0 ? 0 : board.frames);
    $display("over %0d register settings, all four kernels, borders fixed and open",
             phases);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== rgb_conv3x3_stream.f =====
rtl/core/rgbc_pkg.sv
rtl/core/rgb_conv3x3_stream.sv
rtl/core/rgbc_checker.sv
tb/rgbc_tb_pkg.sv
tb/tb_rgb_conv3x3_stream.sv
